FILE: rtl/rhc_pkg.sv
package rhc_pkg;

  // Component width and derived widths
  localparam int CB = 16;
  localparam int SW = CB + 1;   // saturation remainder / divisor width
  localparam int HW = CB + 3;   // hue remainder / divisor width (6*d)
  localparam int QDEPTH = 4;
  localparam int QA = $clog2(QDEPTH);

  // One classified item: divider operands plus pass-through fields
  typedef struct packed {
    logic          grey;
    logic [SW-1:0] sat_rem;
    logic [SW-1:0] sat_den;
    logic [CB-1:0] sat_lo;
    logic [HW-1:0] hue_rem;
    logic [HW-1:0] hue_den;
    logic [CB-1:0] light;
    logic [CB-1:0] alpha;
    logic          last;
  } rhc_item_t;

  // One divider pipeline stage
  typedef struct packed {
    rhc_item_t     it;
    logic [CB-1:0] sat_q;
    logic [CB-1:0] hue_q;
  } rhc_stage_t;

  // Queue status seen by the top level
  typedef struct packed {
    logic [QA:0] count;
    logic        full;
    logic        empty;
  } rhc_qstat_t;

  // One restoring step of both dividers
  function automatic rhc_stage_t rhc_div_step(rhc_stage_t s);
    logic [SW:0] sr;
    logic [HW:0] hr;
    logic        sb;
    logic        hb;
    rhc_stage_t  o;
    o  = s;
    sr = {s.it.sat_rem, s.it.sat_lo[CB-1]};
    sb = 1'b0;
    if (sr >= {1'b0, s.it.sat_den}) begin
      sr = sr - {1'b0, s.it.sat_den};
      sb = 1'b1;
    end
    hr = {s.it.hue_rem, 1'b0};
    hb = 1'b0;
    if (hr >= {1'b0, s.it.hue_den}) begin
      hr = hr - {1'b0, s.it.hue_den};
      hb = 1'b1;
    end
    o.it.sat_lo  = {s.it.sat_lo[CB-2:0], 1'b0};
    o.it.sat_rem = sr[SW-1:0];
    o.it.hue_rem = hr[HW-1:0];
    o.sat_q      = {s.sat_q[CB-2:0], sb};
    o.hue_q      = {s.hue_q[CB-2:0], hb};
    return o;
  endfunction

endpackage

FILE: rtl/rhc_front.sv
module rhc_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [rhc_pkg::CB-1:0] in_red,
  input  logic [rhc_pkg::CB-1:0] in_green,
  input  logic [rhc_pkg::CB-1:0] in_blue,
  input  logic [rhc_pkg::CB-1:0] in_alpha_in,
  input  logic                  in_last_pixel,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  q_full,
  output logic                  push,
  output rhc_pkg::rhc_item_t    push_item
);
  import rhc_pkg::*;

  logic          vld_r;
  rhc_item_t     item_r;
  rhc_item_t     item_nxt;
  logic [CB-1:0] mx, mn, d;
  logic [CB:0]   s;
  logic [2*CB-1:0] num;
  logic [HW-1:0] dw, n;

  // Classify: max/min, divider operands, hue sector numerator
  always_comb begin
    mx = in_red;
    if (in_green > mx) mx = in_green;
    if (in_blue > mx) mx = in_blue;
    mn = in_red;
    if (in_green < mn) mn = in_green;
    if (in_blue < mn) mn = in_blue;
    d   = mx - mn;
    s   = {1'b0, mx} + {1'b0, mn};
    num = {d, {CB{1'b0}}} - {{CB{1'b0}}, d};
    dw  = {3'b0, d};
    if (mx == in_red) begin
      if (in_green >= in_blue) n = {3'b0, in_green - in_blue};
      else n = (dw << 2) + (dw << 1) - {3'b0, in_blue - in_green};
    end else if (mx == in_green) begin
      n = (dw << 1) + {3'b0, in_blue} - {3'b0, in_red};
    end else begin
      n = (dw << 2) + {3'b0, in_red} - {3'b0, in_green};
    end
    item_nxt.grey    = (d == '0);
    item_nxt.sat_rem = {1'b0, num[2*CB-1:CB]};
    item_nxt.sat_den = (s > {1'b0, {CB{1'b1}}}) ? ({{CB{1'b1}}, 1'b0} - s) : s;
    item_nxt.sat_lo  = num[CB-1:0];
    item_nxt.hue_rem = n;
    item_nxt.hue_den = (dw << 2) + (dw << 1);
    item_nxt.light   = s[CB:1];
    item_nxt.alpha   = in_alpha_in;
    item_nxt.last    = in_last_pixel;
  end

  assign push      = vld_r && !q_full;
  assign in_stall  = vld_r && q_full;
  assign push_item = item_r;

  // Front register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (!in_stall) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item_r <= item_nxt;
    end
  end

endmodule

FILE: rtl/rhc_queue.sv
module rhc_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  rhc_pkg::rhc_item_t push_item,
  input  logic               pop,
  output rhc_pkg::rhc_item_t pop_item,
  output rhc_pkg::rhc_qstat_t stat
);
  import rhc_pkg::*;

  rhc_item_t   mem_r [QDEPTH];
  logic [QA-1:0] wp_r, rp_r;
  logic [QA:0]   cnt_r;

  assign stat.count = cnt_r;
  assign stat.full  = (cnt_r == (QA+1)'(QDEPTH));
  assign stat.empty = (cnt_r == '0);
  assign pop_item   = mem_r[rp_r];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_item;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + {{QA{1'b0}}, push} - {{QA{1'b0}}, pop};
    end
  end

endmodule

FILE: rtl/rhc_back.sv
module rhc_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_empty,
  input  rhc_pkg::rhc_item_t    q_item,
  output logic                  pop,
  output logic [rhc_pkg::CB-1:0] out_hue,
  output logic [rhc_pkg::CB-1:0] out_saturation,
  output logic [rhc_pkg::CB-1:0] out_lightness,
  output logic [rhc_pkg::CB-1:0] out_alpha_out,
  output logic                  out_last_out,
  output logic                  out_valid,
  input  logic                  out_stall
);
  import rhc_pkg::*;

  rhc_stage_t st_r  [CB+1];
  logic       vld_r [CB+1];
  logic       en;

  // Whole pipeline advances unless the output holds a stalled item
  assign en  = !vld_r[CB] || !out_stall;
  assign pop = en && !q_empty;

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= CB; k++) vld_r[k] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= !q_empty;
      for (int k = 1; k <= CB; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  // One quotient bit of each divider per stage
  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0].it    <= q_item;
      st_r[0].sat_q <= '0;
      st_r[0].hue_q <= '0;
      for (int k = 1; k <= CB; k++) st_r[k] <= rhc_div_step(st_r[k-1]);
    end
  end

  assign out_valid      = vld_r[CB];
  assign out_hue        = st_r[CB].it.grey ? '0 : st_r[CB].hue_q;
  assign out_saturation = st_r[CB].it.grey ? '0 : st_r[CB].sat_q;
  assign out_lightness  = st_r[CB].it.light;
  assign out_alpha_out  = st_r[CB].it.alpha;
  assign out_last_out   = st_r[CB].it.last;

endmodule

FILE: rtl/rgb_to_hsl_converter.sv
// RGBA to HSLA converter for 16-bit components (65535 = 1.0). One pixel may
// enter every clock while in_stall is low; each result passes through the
// front register, the queue, and a 16-stage divider pipeline that produces one
// quotient bit of hue and of saturation per stage. A 4-item queue sits
// between the classifier and the divider, so the input keeps flowing while
// the output is stalled until the queue fills. Grey pixels give hue and
// saturation 0; alpha and the last marker pass through unchanged.
module rgb_to_hsl_converter (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [rhc_pkg::CB-1:0] in_red,
  input  logic [rhc_pkg::CB-1:0] in_green,
  input  logic [rhc_pkg::CB-1:0] in_blue,
  input  logic [rhc_pkg::CB-1:0] in_alpha_in,
  input  logic                  in_last_pixel,
  input  logic                  in_valid,
  output logic                  in_stall,
  output logic [rhc_pkg::CB-1:0] out_hue,
  output logic [rhc_pkg::CB-1:0] out_saturation,
  output logic [rhc_pkg::CB-1:0] out_lightness,
  output logic [rhc_pkg::CB-1:0] out_alpha_out,
  output logic                  out_last_out,
  output logic                  out_valid,
  input  logic                  out_stall
);
  import rhc_pkg::*;

  logic       push, pop;
  rhc_item_t  push_item, pop_item;
  rhc_qstat_t qstat;

  rhc_front u_front (
    .clk, .rst_n, .in_red, .in_green, .in_blue, .in_alpha_in, .in_last_pixel,
    .in_valid, .in_stall, .q_full(qstat.full), .push, .push_item
  );

  rhc_queue u_queue (
    .clk, .rst_n, .push, .push_item, .pop, .pop_item, .stat(qstat)
  );

  rhc_back u_back (
    .clk, .rst_n, .q_empty(qstat.empty), .q_item(pop_item), .pop,
    .out_hue, .out_saturation, .out_lightness, .out_alpha_out, .out_last_out,
    .out_valid, .out_stall
  );

  // Queue never overfills
  a_qcount: assert property (@(posedge clk) disable iff (!rst_n)
    qstat.count <= (QA+1)'(QDEPTH)) else $error("queue overflow");

  // No pop from an empty queue, no push into a full one
  a_qpop: assert property (@(posedge clk) disable iff (!rst_n)
    qstat.empty |-> !pop) else $error("pop from empty queue");

  a_qpush: assert property (@(posedge clk) disable iff (!rst_n)
    qstat.full |-> !push) else $error("push into full queue");

endmodule
